// ===== rtl/core/ntx_pkg.sv =====
// shared types, constants and codes of the per-neighbor transmit statistics table
// no dependencies
package ntx_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int COUNTER_BITS_DEF  = 32;
  localparam int QUEUE_DEPTH       = 2;

  localparam int MAC_W    = 48;
  localparam int RETRY_W  = 8;
  localparam int RATE_W   = 8;
  localparam int RSLOT_W  = 4;
  localparam int STATUS_W = 3;
  localparam int OUT_CNT_W = 32;

  localparam logic [MAC_W-1:0] BCAST_MAC = 48'hffff_ffff_ffff;

  localparam logic [STATUS_W-1:0] STATUS_UPDATED = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_BCAST = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_READ = 3'd4;

  typedef enum logic [1:0] {
    KIND_LOOKUP,
    KIND_BCAST,
    KIND_READ
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [MAC_W-1:0]     mac;
    logic                 tx_ok;
    logic [RETRY_W-1:0]   long_retry;
    logic [RETRY_W-1:0]   short_retry;
    logic [RATE_W-1:0]    rate;
    logic [RSLOT_W-1:0]   read_slot;
    logic                 rd_in_range;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 entry_valid;
    logic [RSLOT_W-1:0]   slot;
    logic [MAC_W-1:0]     mac;
    logic [OUT_CNT_W-1:0] packets;
    logic [OUT_CNT_W-1:0] failures;
    logic [OUT_CNT_W-1:0] lr_total;
    logic [OUT_CNT_W-1:0] sr_total;
    logic [RATE_W-1:0]    rate;
  } result_t;

endpackage

// ===== rtl/core/ntx_front.sv =====
// input side: handshake and classification of incoming transactions
// depends on ntx_pkg
module ntx_front import ntx_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic [MAC_W-1:0]   dest_mac_i,
  input  logic               tx_ok_i,
  input  logic [RETRY_W-1:0] long_retry_count_i,
  input  logic [RETRY_W-1:0] short_retry_count_i,
  input  logic [RATE_W-1:0]  tx_rate_i,
  input  logic [RSLOT_W-1:0] read_slot_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output item_t              q_item_o
);

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.mac         = dest_mac_i;
    q_item_o.tx_ok       = tx_ok_i;
    q_item_o.long_retry  = long_retry_count_i;
    q_item_o.short_retry = short_retry_count_i;
    q_item_o.rate        = tx_rate_i;
    q_item_o.read_slot   = read_slot_i;
    q_item_o.rd_in_range = (32'(read_slot_i) < 32'(TABLE_ENTRIES));
    if (mode_i) begin
      q_item_o.kind = KIND_READ;
    end else if (dest_mac_i == BCAST_MAC) begin
      q_item_o.kind = KIND_BCAST;
    end else begin
      q_item_o.kind = KIND_LOOKUP;
    end
  end

endmodule

// ===== rtl/core/ntx_fifo.sv =====
// short queue of classified transactions between front and back
// depends on ntx_pkg
module ntx_fifo import ntx_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  item_t            buf_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = buf_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/core/ntx_back.sv =====
// back end: key match, slot selection, record update and the result register
// depends on ntx_pkg
module ntx_back import ntx_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int COUNTER_BITS  = COUNTER_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  input  item_t   q_item_i,
  output logic    q_pop_o,
  output logic    res_valid_o,
  output result_t res_o,
  input  logic    out_stall_i
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [1:0] ST_FETCH = 2'd0;
  localparam logic [1:0] ST_SEL   = 2'd1;
  localparam logic [1:0] ST_UPD   = 2'd2;

  typedef struct packed {
    logic [MAC_W-1:0]        mac;
    logic [COUNTER_BITS-1:0] packets;
    logic [COUNTER_BITS-1:0] failures;
    logic [COUNTER_BITS-1:0] lr_total;
    logic [COUNTER_BITS-1:0] sr_total;
    logic [RATE_W-1:0]       rate;
  } rec_t;

  logic [1:0]               state_q, state_d;
  logic [TABLE_ENTRIES-1:0] used_q;
  logic [MAC_W-1:0]         key_q [TABLE_ENTRIES];
  rec_t                     rec_mem [TABLE_ENTRIES];
  rec_t                     rd_q;
  logic [TABLE_ENTRIES-1:0] hit_q, hit_d, free_q;
  item_t                    item_q;
  logic [IDX_W-1:0]         slot_q, slot_d;
  logic [STATUS_W-1:0]      status_q, status_d;
  logic                     mem_re, go, wr_en;
  logic                     res_valid_q, res_valid_d;
  result_t                  res_q, res_d;
  rec_t                     new_rec;

  logic [IDX_W-1:0]         hit_idx, free_idx, read_idx;
  logic                     hit_any, free_any;
  logic [IDX_W+RSLOT_W-1:0] read_wide;

  assign q_pop_o = (state_q == ST_FETCH) && q_valid_i;
  assign go      = !res_valid_q || !out_stall_i;
  assign wr_en   = (state_q == ST_UPD) && go &&
                   ((status_q == STATUS_UPDATED) || (status_q == STATUS_INSERTED));

  // parallel key compare on the queue head
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_d[i] = used_q[i] && (key_q[i] == q_item_i.mac);
    end
  end

  // lowest matching slot and lowest free slot
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (free_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    hit_any  = |hit_q;
    free_any = |free_q;
  end

  assign read_wide = {{IDX_W{1'b0}}, item_q.read_slot};
  assign read_idx  = read_wide[IDX_W-1:0];

  always_comb begin
    slot_d   = '0;
    status_d = STATUS_FULL;
    mem_re   = 1'b0;
    case (item_q.kind)
      KIND_READ: begin
        slot_d   = read_idx;
        status_d = STATUS_READ;
        mem_re   = item_q.rd_in_range;
      end
      KIND_BCAST: begin
        status_d = STATUS_BCAST;
      end
      KIND_LOOKUP: begin
        if (hit_any) begin
          slot_d   = hit_idx;
          status_d = STATUS_UPDATED;
          mem_re   = 1'b1;
        end else if (free_any) begin
          slot_d   = free_idx;
          status_d = STATUS_INSERTED;
        end
      end
      default: begin
        status_d = STATUS_FULL;
      end
    endcase
    mem_re = mem_re && (state_q == ST_SEL);
  end

  always_comb begin
    logic                          used_here;
    rec_t                          base;
    rec_t                          shown;
    logic [IDX_W+RSLOT_W-1:0]      slot_wide;
    logic [COUNTER_BITS+OUT_CNT_W-1:0] w_pkt, w_fail, w_lr, w_sr;

    used_here = item_q.rd_in_range && used_q[slot_q];
    base      = used_q[slot_q] ? rd_q : '0;
    if (status_q == STATUS_INSERTED) begin
      base = '0;
    end

    new_rec.mac      = item_q.mac;
    new_rec.packets  = base.packets + 1'b1;
    new_rec.failures = base.failures + {{(COUNTER_BITS-1){1'b0}}, ~item_q.tx_ok};
    new_rec.lr_total = base.lr_total + COUNTER_BITS'(item_q.long_retry);
    new_rec.sr_total = base.sr_total + COUNTER_BITS'(item_q.short_retry);
    new_rec.rate     = item_q.rate;

    slot_wide = {{RSLOT_W{1'b0}}, slot_q};
    res_d     = '0;
    shown     = '0;
    res_d.status = status_q;
    case (status_q)
      STATUS_UPDATED, STATUS_INSERTED: begin
        res_d.entry_valid = 1'b1;
        res_d.slot        = slot_wide[RSLOT_W-1:0];
        shown             = new_rec;
      end
      STATUS_READ: begin
        res_d.entry_valid = used_here;
        res_d.slot        = item_q.read_slot;
        shown             = used_here ? rd_q : '0;
      end
      default: begin
        shown = '0;
      end
    endcase

    w_pkt  = {{OUT_CNT_W{1'b0}}, shown.packets};
    w_fail = {{OUT_CNT_W{1'b0}}, shown.failures};
    w_lr   = {{OUT_CNT_W{1'b0}}, shown.lr_total};
    w_sr   = {{OUT_CNT_W{1'b0}}, shown.sr_total};
    res_d.mac      = shown.mac;
    res_d.packets  = w_pkt[OUT_CNT_W-1:0];
    res_d.failures = w_fail[OUT_CNT_W-1:0];
    res_d.lr_total = w_lr[OUT_CNT_W-1:0];
    res_d.sr_total = w_sr[OUT_CNT_W-1:0];
    res_d.rate     = shown.rate;
  end

  always_comb begin
    state_d     = state_q;
    res_valid_d = res_valid_q;
    if (res_valid_q && !out_stall_i) begin
      res_valid_d = 1'b0;
    end
    case (state_q)
      ST_FETCH: begin
        if (q_valid_i) begin
          state_d = ST_SEL;
        end
      end
      ST_SEL: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (go) begin
          state_d     = ST_FETCH;
          res_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FETCH;
      used_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (wr_en) begin
        used_q[slot_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
      hit_q  <= hit_d;
      free_q <= ~used_q;
    end
    if (state_q == ST_SEL) begin
      slot_q   <= slot_d;
      status_q <= status_d;
    end
    if (wr_en) begin
      key_q[slot_q] <= item_q.mac;
    end
    if ((state_q == ST_UPD) && go) begin
      res_q <= res_d;
    end
  end

  // record storage: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rec_mem[slot_q] <= new_rec;
    end
    if (mem_re) begin
      rd_q <= rec_mem[slot_d];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/core/per_neighbor_tx_stats_table.sv =====
// per-neighbor transmit statistics table, top level
// an accepted transaction passes the queue, then the back end sequencer states in order
// (fetch with key compare, select with record read, update with record write and result register);
// update waits while out_stall_i holds a pending result, and a new transaction is fetched only after it
// reset clears the slot-used flags at once; no clearing pass, records of unused slots read as zero
// depends on ntx_pkg, ntx_front, ntx_fifo, ntx_back
module per_neighbor_tx_stats_table import ntx_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int COUNTER_BITS  = COUNTER_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 mode_i,
  input  logic [MAC_W-1:0]     dest_mac_i,
  input  logic                 tx_ok_i,
  input  logic [RETRY_W-1:0]   long_retry_count_i,
  input  logic [RETRY_W-1:0]   short_retry_count_i,
  input  logic [RATE_W-1:0]    tx_rate_i,
  input  logic [RSLOT_W-1:0]   read_slot_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic                 entry_valid_o,
  output logic [RSLOT_W-1:0]   slot_o,
  output logic [MAC_W-1:0]     entry_mac_o,
  output logic [OUT_CNT_W-1:0] packets_total_o,
  output logic [OUT_CNT_W-1:0] failures_total_o,
  output logic [OUT_CNT_W-1:0] long_retries_total_o,
  output logic [OUT_CNT_W-1:0] short_retries_total_o,
  output logic [RATE_W-1:0]    last_rate_o
);

  logic    q_full, q_push, q_valid, q_pop;
  item_t   push_item, head_item;
  result_t res;

  ntx_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .dest_mac_i         (dest_mac_i),
    .tx_ok_i            (tx_ok_i),
    .long_retry_count_i (long_retry_count_i),
    .short_retry_count_i(short_retry_count_i),
    .tx_rate_i          (tx_rate_i),
    .read_slot_i        (read_slot_i),
    .q_full_i           (q_full),
    .q_push_o           (q_push),
    .q_item_o           (push_item)
  );

  ntx_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (push_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .item_o (head_item)
  );

  ntx_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (head_item),
    .q_pop_o    (q_pop),
    .res_valid_o(out_valid_o),
    .res_o      (res),
    .out_stall_i(out_stall_i)
  );

  assign status_o              = res.status;
  assign entry_valid_o         = res.entry_valid;
  assign slot_o                = res.slot;
  assign entry_mac_o           = res.mac;
  assign packets_total_o       = res.packets;
  assign failures_total_o      = res.failures;
  assign long_retries_total_o  = res.lr_total;
  assign short_retries_total_o = res.sr_total;
  assign last_rate_o           = res.rate;

`ifndef SYNTHESIS
  a_valid_only_with_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_valid_o |->
      (status_o == STATUS_UPDATED) || (status_o == STATUS_INSERTED) ||
      (status_o == STATUS_READ))
    else $error("entry_valid set on a result without a record");

  a_update_has_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == STATUS_UPDATED) || (status_o == STATUS_INSERTED)) |->
      entry_valid_o)
    else $error("update or insert result without entry_valid");

  a_dropped_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == STATUS_BCAST) || (status_o == STATUS_FULL)) |->
      (slot_o == '0) && (entry_mac_o == '0) && (packets_total_o == '0) &&
      (failures_total_o == '0) && (last_rate_o == '0))
    else $error("ignored or dropped transaction returned a nonzero record");

  a_unused_read_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_READ) && !entry_valid_o |->
      (packets_total_o == '0) && (failures_total_o == '0) &&
      (long_retries_total_o == '0) && (short_retries_total_o == '0))
    else $error("read of an unused slot returned nonzero counters");
`endif

endmodule
